>>> src/cbs_pkg.sv
// ----------------------------------------------------------------------------
// cbs_pkg
// shared types, constants and state codes of the bounding sphere block
// ----------------------------------------------------------------------------
package cbs_pkg;

   localparam int MAX_POINTS = 256;
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int COORD_W    = 24;
   localparam int SUM_W      = COORD_W + CNT_W;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int SQ_W       = 2 * DIFF_W;
   localparam int DIST_W     = SQ_W + 2;
   localparam int RAD_W      = 25;
   localparam int ROOT_W     = DIST_W / 2;
   localparam int QUO_W      = SUM_W;

   localparam logic [RAD_W-1:0] UNIT_RADIUS = RAD_W'(256);

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic                      last_point;
      logic                      empty_list;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_z;
      logic        [RAD_W-1:0]   sphere_radius;
      logic                      points_dropped;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_DIV_NEXT,
      ST_SCAN_RD,
      ST_SCAN_X,
      ST_SCAN_Y,
      ST_SCAN_Z,
      ST_SCAN_ACC,
      ST_SQRT,
      ST_OUT
   } state_type;

endpackage

>>> src/cbs_divider.sv
// ----------------------------------------------------------------------------
// cbs_divider
// restoring divider, one quotient bit per cycle, signed truncating result
// ----------------------------------------------------------------------------
module cbs_divider
   import cbs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [SUM_W-1:0]  dividend,
   input  logic        [CNT_W-1:0]  divisor,
   output logic                     busy,
   output logic signed [COORD_W-1:0] quotient
);

   localparam int STEP_W = $clog2(QUO_W + 1);

   logic [QUO_W-1:0]  num_ff, num_in;
   logic [CNT_W:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]  den_ff, den_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              neg_ff, neg_in;
   logic              busy_ff, busy_in;
   logic [CNT_W:0]    trial;
   logic [QUO_W-1:0]  mag;

   always_comb begin
      mag     = dividend[SUM_W-1] ? QUO_W'(-dividend) : QUO_W'(dividend);
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[CNT_W-1:0], num_ff[QUO_W-1]};
      if (start) begin
         num_in  = mag;
         rem_in  = '0;
         den_in  = divisor;
         step_in = STEP_W'(QUO_W);
         neg_in  = dividend[SUM_W-1];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            num_in = {num_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            num_in = {num_ff[QUO_W-2:0], 1'b0};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign busy     = busy_ff;
   assign quotient = neg_ff ? -COORD_W'(num_ff) : COORD_W'(num_ff);

endmodule

>>> src/cbs_sqrt.sv
// ----------------------------------------------------------------------------
// cbs_sqrt
// digit-by-digit integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
module cbs_sqrt
   import cbs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIST_W-1:0] radicand,
   output logic              busy,
   output logic [RAD_W-1:0]  root
);

   localparam int STEP_W = $clog2(ROOT_W + 1);

   logic [DIST_W-1:0] num_ff, num_in;
   logic [ROOT_W+1:0] rem_ff, rem_in;
   logic [ROOT_W-1:0] res_ff, res_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic [ROOT_W+1:0] trial;
   logic [ROOT_W+1:0] sub;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[ROOT_W-1:0], num_ff[DIST_W-1:DIST_W-2]};
      sub     = {res_ff, 2'b01};
      if (start) begin
         num_in  = radicand;
         rem_in  = '0;
         res_in  = '0;
         step_in = STEP_W'(ROOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[DIST_W-3:0], 2'b00};
         if (trial >= sub) begin
            rem_in = trial - sub;
            res_in = {res_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            res_in = {res_ff[ROOT_W-2:0], 1'b0};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
   end

   assign busy = busy_ff;
   assign root = RAD_W'(res_ff);

endmodule

>>> src/centroid_bounding_sphere.sv
// ----------------------------------------------------------------------------
// centroid_bounding_sphere
// bounding sphere of a point list around its centroid
// ----------------------------------------------------------------------------
// points arrive on the req_ channel one per transfer and are stored and
// summed as each is taken; a point is taken every cycle while the list
// is filling. a transfer marked last_point starts the computation and the
// block drops req_ready until the result is handed off on the rsp_ channel:
// three serial divides for the centroid, a scan of the point store that
// steps through the read, x, y, z and accumulate states for each stored
// point through one shared multiplier, and a square root. empty_list
// answers with the unit sphere on the cycle after its transfer. the result
// stays in its output register while rsp_ready is low and no new point is
// taken until it is transferred. reset clears the sums, count and control
// state; the point store needs no clearing since only entries written in
// the current list are read.
// ----------------------------------------------------------------------------
module centroid_bounding_sphere
   import cbs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   state_type state_ff, state_in;

   logic [3*COORD_W-1:0] store_mem [MAX_POINTS];
   logic [3*COORD_W-1:0] rd_data_ff;

   logic signed [SUM_W-1:0]   sum_x_ff, sum_y_ff, sum_z_ff;
   logic [CNT_W-1:0]          count_ff;
   logic                      ovf_ff;
   logic [1:0]                axis_ff, axis_in;
   logic [ADDR_W:0]           idx_ff, idx_in;
   logic signed [COORD_W-1:0] cx_ff, cy_ff, cz_ff;
   logic signed [DIFF_W-1:0]  diff;
   logic [SQ_W-1:0]           sq_ff;
   logic [DIST_W-1:0]         dist_ff, best_ff;
   rsp_type                   rsp_ff;
   logic                      rsp_valid_ff;

   logic                      accept, store_ok;
   logic                      div_start, div_busy;
   logic                      sq_start, sq_busy;
   logic signed [SUM_W-1:0]   div_dividend;
   logic signed [COORD_W-1:0] div_q;
   logic [RAD_W-1:0]          root;

   assign accept   = req_valid && req_ready;
   assign store_ok = count_ff < CNT_W'(MAX_POINTS);

   cbs_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .busy     (div_busy),
      .quotient (div_q)
   );

   cbs_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (best_ff),
      .busy     (sq_busy),
      .root     (root)
   );

   always_comb begin
      unique case (axis_ff)
         2'd0:    div_dividend = sum_x_ff;
         2'd1:    div_dividend = sum_y_ff;
         default: div_dividend = sum_z_ff;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !req_data.empty_list && req_data.last_point) begin
               state_in = ST_DIV;
               axis_in  = 2'd0;
            end else if (accept && req_data.empty_list) begin
               state_in = ST_OUT;
            end
         end
         ST_DIV: state_in = ST_DIV_NEXT;
         ST_DIV_NEXT: begin
            if (!div_busy) begin
               if (axis_ff == 2'd2) begin
                  state_in = ST_SCAN_RD;
                  idx_in   = '0;
               end else begin
                  state_in = ST_DIV;
                  axis_in  = axis_ff + 2'd1;
               end
            end
         end
         ST_SCAN_RD: begin
            if (idx_ff == (ADDR_W + 1)'(count_ff)) begin
               state_in = ST_SQRT;
            end else begin
               state_in = ST_SCAN_X;
            end
         end
         ST_SCAN_X:   state_in = ST_SCAN_Y;
         ST_SCAN_Y:   state_in = ST_SCAN_Z;
         ST_SCAN_Z:   state_in = ST_SCAN_ACC;
         ST_SCAN_ACC: begin
            state_in = ST_SCAN_RD;
            idx_in   = idx_ff + 1'b1;
         end
         ST_SQRT: begin
            if (sq_busy) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff && !sq_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
      div_start = (state_ff == ST_DIV);
      sq_start  = (state_ff == ST_SQRT) && !sq_busy;
      unique case (state_ff)
         ST_SCAN_Y: diff = DIFF_W'(signed'(rd_data_ff[2*COORD_W-1:COORD_W])) -
                           DIFF_W'(cy_ff);
         ST_SCAN_Z: diff = DIFF_W'(signed'(rd_data_ff[COORD_W-1:0])) -
                           DIFF_W'(cz_ff);
         default:   diff = DIFF_W'(signed'(rd_data_ff[3*COORD_W-1:2*COORD_W])) -
                           DIFF_W'(cx_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept && !req_data.empty_list && store_ok) begin
         store_mem[count_ff[ADDR_W-1:0]] <=
            {req_data.point_x, req_data.point_y, req_data.point_z};
      end
      rd_data_ff <= store_mem[idx_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         sum_z_ff     <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         axis_ff      <= '0;
         idx_ff       <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         idx_ff   <= idx_in;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept) begin
            if (req_data.empty_list) begin
               rsp_valid_ff <= 1'b1;
               sum_x_ff     <= '0;
               sum_y_ff     <= '0;
               sum_z_ff     <= '0;
               count_ff     <= '0;
               ovf_ff       <= 1'b0;
            end else if (store_ok) begin
               sum_x_ff <= sum_x_ff + SUM_W'(req_data.point_x);
               sum_y_ff <= sum_y_ff + SUM_W'(req_data.point_y);
               sum_z_ff <= sum_z_ff + SUM_W'(req_data.point_z);
               count_ff <= count_ff + 1'b1;
            end else begin
               ovf_ff <= 1'b1;
            end
         end
         if (state_ff == ST_OUT && !rsp_valid_ff && !sq_busy &&
             count_ff != '0) begin
            rsp_valid_ff <= 1'b1;
            sum_x_ff     <= '0;
            sum_y_ff     <= '0;
            sum_z_ff     <= '0;
            count_ff     <= '0;
            ovf_ff       <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DIV_NEXT && !div_busy) begin
         unique case (axis_ff)
            2'd0:    cx_ff <= div_q;
            2'd1:    cy_ff <= div_q;
            default: cz_ff <= div_q;
         endcase
      end
      if (state_ff == ST_DIV && axis_ff == 2'd0) begin
         best_ff <= '0;
      end
      if (state_ff == ST_SCAN_X || state_ff == ST_SCAN_Y || state_ff == ST_SCAN_Z) begin
         sq_ff <= SQ_W'(diff * diff);
      end
      if (state_ff == ST_SCAN_Y) begin
         dist_ff <= DIST_W'(sq_ff);
      end else if (state_ff == ST_SCAN_Z || state_ff == ST_SCAN_ACC) begin
         dist_ff <= dist_ff + DIST_W'(sq_ff);
      end
      if (state_ff == ST_SCAN_RD && idx_ff != '0 && dist_ff > best_ff) begin
         best_ff <= dist_ff;
      end
      if (accept && req_data.empty_list) begin
         rsp_ff <= '{center_x: '0, center_y: '0, center_z: '0,
                     sphere_radius: UNIT_RADIUS, points_dropped: 1'b0};
      end else if (state_ff == ST_OUT && !rsp_valid_ff && !sq_busy) begin
         rsp_ff <= '{center_x: cx_ff, center_y: cy_ff, center_z: cz_ff,
                     sphere_radius: root, points_dropped: ovf_ff};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_ready)
      else $error("point taken while computing");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count beyond store depth");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("result changed while stalled");

   a_div_idle_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN_RD |-> !div_busy)
      else $error("divider busy during scan");

endmodule

>>> tb/sv/centroid_bounding_sphere_tb.sv
// ----------------------------------------------------------------------------
// centroid_bounding_sphere_tb
// self-checking bench for the centroid bounding sphere block
// ----------------------------------------------------------------------------
// point lists of random length and content are sent on the req_ channel with
// bursty gaps, while the rsp_ channel stalls on its own pattern. a sphere
// scoreboard predicts the centroid, radius and drop flag of every finished
// list and compares each result transfer field by field, oldest first.
// lists cover empty, single point, extreme coordinates and store overflow.
// ----------------------------------------------------------------------------
import cbs_pkg::*;

class sphere_scoreboard;
   logic signed [COORD_W-1:0] px[MAX_POINTS];
   logic signed [COORD_W-1:0] py[MAX_POINTS];
   logic signed [COORD_W-1:0] pz[MAX_POINTS];
   longint sx, sy, sz;
   int count;
   bit dropped;
   rsp_type sphere_q[$];
   int errors;
   int spheres;

   function new();
      sx = 0; sy = 0; sz = 0; count = 0; dropped = 0;
      errors = 0; spheres = 0;
   endfunction

   function longint unsigned sq(longint a, longint b);
      longint d;
      d = a - b;
      if (d < 0) d = -d;
      return d * d;
   endfunction

   function longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned root, bit_v;
      root = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v >>= 2;
      while (bit_v != 0) begin
         if (n >= root + bit_v) begin
            n -= root + bit_v;
            root = (root >> 1) + bit_v;
         end else begin
            root >>= 1;
         end
         bit_v >>= 2;
      end
      return root;
   endfunction

   function void note_point(req_type r);
      rsp_type e;
      longint cx, cy, cz;
      longint unsigned best, d;
      if (r.empty_list) begin
         e = '0;
         e.sphere_radius = UNIT_RADIUS;
         sphere_q.push_back(e);
         sx = 0; sy = 0; sz = 0; count = 0; dropped = 0;
         return;
      end
      if (count < MAX_POINTS) begin
         px[count] = r.point_x; py[count] = r.point_y; pz[count] = r.point_z;
         sx += r.point_x; sy += r.point_y; sz += r.point_z;
         count++;
      end else begin
         dropped = 1;
      end
      if (!r.last_point) return;
      cx = sx / count; cy = sy / count; cz = sz / count;
      best = 0;
      for (int i = 0; i < count; i++) begin
         d = sq(px[i], cx) + sq(py[i], cy) + sq(pz[i], cz);
         if (d > best) best = d;
      end
      e.center_x = cx[COORD_W-1:0];
      e.center_y = cy[COORD_W-1:0];
      e.center_z = cz[COORD_W-1:0];
      e.sphere_radius = RAD_W'(floor_sqrt(best));
      e.points_dropped = dropped;
      sphere_q.push_back(e);
      sx = 0; sy = 0; sz = 0; count = 0; dropped = 0;
   endfunction

   function void check_sphere(rsp_type a);
      rsp_type e;
      if (sphere_q.size() == 0) begin
         $error("result transfer with nothing expected");
         errors++;
         return;
      end
      e = sphere_q.pop_front();
      spheres++;
      if (a.center_x !== e.center_x) begin
         $error("center_x expected %0d actual %0d", e.center_x, a.center_x); errors++;
      end
      if (a.center_y !== e.center_y) begin
         $error("center_y expected %0d actual %0d", e.center_y, a.center_y); errors++;
      end
      if (a.center_z !== e.center_z) begin
         $error("center_z expected %0d actual %0d", e.center_z, a.center_z); errors++;
      end
      if (a.sphere_radius !== e.sphere_radius) begin
         $error("sphere_radius expected %0d actual %0d", e.sphere_radius,
                a.sphere_radius); errors++;
      end
      if (a.points_dropped !== e.points_dropped) begin
         $error("points_dropped expected %0d actual %0d", e.points_dropped,
                a.points_dropped); errors++;
      end
   endfunction
endclass

module centroid_bounding_sphere_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_data;

   sphere_scoreboard board = new();
   int points_sent = 0;
   int burst_left = 0;
   bit stall_mode = 0;

   centroid_bounding_sphere DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) board.note_point(req_data);
      if (!reset && rsp_valid && rsp_ready) board.check_sphere(rsp_data);
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
      if (stall_mode) rsp_ready <= ($urandom_range(0, 3) != 0) ? 1'b0 : 1'b1;
      else rsp_ready <= 1'b1;
   end

   function logic signed [COORD_W-1:0] pick_coord(int mode);
      case (mode)
         0: return 24'sh7FFFFF;
         1: return 24'sh800000;
         2: return COORD_W'($urandom_range(0, 4095)) - 24'sd2048;
         default: return COORD_W'($urandom);
      endcase
   endfunction

   // valid stays high between transfers of a burst
   task send_point(req_type r);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      points_sent++;
      @(negedge clock);
   endtask

   task send_list(int n, int mode, bit empty_end);
      req_type r;
      for (int i = 0; i < n; i++) begin
         r.point_x = pick_coord(mode);
         r.point_y = pick_coord(mode);
         r.point_z = pick_coord(mode);
         r.empty_list = 1'b0;
         r.last_point = (i == n - 1) && !empty_end;
         send_point(r);
      end
      if (empty_end) begin
         r = req_type'($bits(req_type)'({$urandom, $urandom, $urandom}));
         r.empty_list = 1'b1;
         send_point(r);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed lists
      send_list(0, 0, 1);
      send_list(1, 0, 0);
      send_list(1, 1, 0);
      send_list(2, 2, 0);
      send_list(3, 3, 0);
      send_list(4, 2, 1);
      begin
         req_type r;
         r = '0; r.point_x = 24'sh7FFFFF; r.point_y = 24'sh7FFFFF; r.point_z = 24'sh7FFFFF;
         send_point(r);
         r.point_x = 24'sh800000; r.point_y = 24'sh800000; r.point_z = 24'sh800000;
         r.last_point = 1'b1;
         send_point(r);
      end
      // store overflow, once with the last point dropped
      send_list(MAX_POINTS + 3, 3, 0);
      // random lists
      while (points_sent < 1550) begin
         int k;
         k = $urandom_range(0, 19);
         if (k == 0) send_list(MAX_POINTS + $urandom_range(0, 2), $urandom_range(0, 3), 0);
         else if (k == 1) send_list($urandom_range(0, 6), 3, 1);
         else send_list($urandom_range(1, 16), $urandom_range(0, 3), 0);
      end
      req_valid <= 1'b0;
      while (board.sphere_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("sent %0d points, checked %0d spheres incl. empty and overflow lists",
               points_sent, board.spheres);
      if (board.errors == 0 && board.sphere_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #8ms;
      $display("timeout");
      $display("*** FAILED ***");
      $finish;
   end
endmodule
